FILE: rtl/core/quadratic_calibrated_histogram_core_defines.svh
// ----------------------------------------------------------------------------
// quadratic calibrated histogram: assertion macros
// shared assertion forms for the histogram core, clocked on clk, off in reset
// ----------------------------------------------------------------------------
`ifndef QUADRATIC_CALIBRATED_HISTOGRAM_CORE_DEFINES_SVH
`define QUADRATIC_CALIBRATED_HISTOGRAM_CORE_DEFINES_SVH

// same-cycle implication
`define QCH_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("qchist: same-cycle check failed");

// next-cycle implication
`define QCH_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("qchist: next-cycle check failed");

`endif

FILE: rtl/core/qchist_pkg.sv
// ----------------------------------------------------------------------------
// qchist_pkg
// widths, codes and control/status types shared by the histogram core
// ----------------------------------------------------------------------------
package qchist_pkg;

	localparam int MAX_BINS    = 256;
	localparam int SLOTS       = MAX_BINS + 2;
	localparam int ADDR_W      = $clog2(SLOTS);

	localparam int DATA_W      = 32;
	localparam int COUNT_W     = 32;
	localparam int SLOT_W      = 9;
	localparam int NB_W        = 9;
	localparam int BPU_W       = 31;
	localparam int Q_FRAC      = 16;
	localparam int SCALE_SHIFT = 32;
	localparam int IDX_W       = 31;
	localparam int MUL_W       = DATA_W + 1;
	localparam int PROD_W      = 2 * MUL_W;
	localparam int SQ_W        = 47;
	localparam int ACC_W       = 80;

	localparam int CFG_IDX_W   = 3;
	localparam int CFG_DATA_W  = 32;
	localparam int IN_TDATA_W  = 48;
	localparam int OUT_TDATA_W = 48;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_COEF_LINEAR    = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_COEF_QUADRATIC = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_RANGE_LOW      = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_BINS_PER_UNIT  = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_BINS_IN_USE    = 3'd4;

	// item kinds
	localparam logic CMD_FILL = 1'b0;
	localparam logic CMD_READ = 1'b1;

	// multiplier operand selection
	localparam int MUL_SEL_W = 3;
	localparam logic [MUL_SEL_W-1:0] MUL_SQ  = 3'd0;
	localparam logic [MUL_SEL_W-1:0] MUL_AE  = 3'd1;
	localparam logic [MUL_SEL_W-1:0] MUL_BH  = 3'd2;
	localparam logic [MUL_SEL_W-1:0] MUL_BL  = 3'd3;
	localparam logic [MUL_SEL_W-1:0] MUL_SCL = 3'd4;

	typedef struct packed {
		logic                 load_item;
		logic                 mul_en;
		logic [MUL_SEL_W-1:0] mul_sel;
		logic                 sq_load;
		logic                 acc_load;
		logic                 acc_add_hi;
		logic                 acc_add_lo;
		logic                 sat_load;
		logic                 bin_load;
		logic                 ram_re;
		logic                 ram_we_inc;
		logic                 clr_step;
		logic                 load_out;
	} qchist_cmd_t;

	typedef struct packed {
		logic clr_done;
		logic out_busy;
	} qchist_sts_t;

endpackage

FILE: rtl/core/qchist_ram.sv
// ----------------------------------------------------------------------------
// qchist_ram
// generic simple dual-port ram, one write and one registered read port
// ----------------------------------------------------------------------------
module qchist_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 258,
	localparam int ADDR_W = $clog2(DEPTH)
) (
	input  logic              clk,
	input  logic              we,
	input  logic [ADDR_W-1:0] waddr,
	input  logic [WIDTH-1:0]  wdata,
	input  logic              re,
	input  logic [ADDR_W-1:0] raddr,
	output logic [WIDTH-1:0]  rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

FILE: rtl/core/qchist_ctrl.sv
// ----------------------------------------------------------------------------
// qchist_ctrl
// sequencer for clear pass, fill steps on the shared multiplier and bin reads
// ----------------------------------------------------------------------------
module qchist_ctrl (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     in_valid,
	input  logic                     in_cmd,
	output logic                     in_ready,
	input  qchist_pkg::qchist_sts_t  sts,
	output qchist_pkg::qchist_cmd_t  cmd
);
	import qchist_pkg::*;

	localparam int ST_W = 4;
	localparam logic [ST_W-1:0] ST_CLEAR  = 4'd0;
	localparam logic [ST_W-1:0] ST_IDLE   = 4'd1;
	localparam logic [ST_W-1:0] ST_SQ     = 4'd2;
	localparam logic [ST_W-1:0] ST_AE     = 4'd3;
	localparam logic [ST_W-1:0] ST_BH     = 4'd4;
	localparam logic [ST_W-1:0] ST_BL     = 4'd5;
	localparam logic [ST_W-1:0] ST_SUM    = 4'd6;
	localparam logic [ST_W-1:0] ST_SAT    = 4'd7;
	localparam logic [ST_W-1:0] ST_SCL    = 4'd8;
	localparam logic [ST_W-1:0] ST_BIN    = 4'd9;
	localparam logic [ST_W-1:0] ST_RMW_RD = 4'd10;
	localparam logic [ST_W-1:0] ST_RMW_WR = 4'd11;
	localparam logic [ST_W-1:0] ST_RD_REQ = 4'd12;
	localparam logic [ST_W-1:0] ST_RD_OUT = 4'd13;

	logic [ST_W-1:0] state_q;
	logic [ST_W-1:0] state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_ready = 1'b0;
		case (state_q)
			ST_CLEAR: begin
				cmd.clr_step = 1'b1;
				if (sts.clr_done) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load_item = 1'b1;
					state_d = (in_cmd == CMD_READ) ? ST_RD_REQ : ST_SQ;
				end
			end
			ST_SQ: begin
				cmd.mul_en  = 1'b1;
				cmd.mul_sel = MUL_SQ;
				state_d     = ST_AE;
			end
			ST_AE: begin
				cmd.sq_load = 1'b1;
				cmd.mul_en  = 1'b1;
				cmd.mul_sel = MUL_AE;
				state_d     = ST_BH;
			end
			ST_BH: begin
				cmd.acc_load = 1'b1;
				cmd.mul_en   = 1'b1;
				cmd.mul_sel  = MUL_BH;
				state_d      = ST_BL;
			end
			ST_BL: begin
				cmd.acc_add_hi = 1'b1;
				cmd.mul_en     = 1'b1;
				cmd.mul_sel    = MUL_BL;
				state_d        = ST_SUM;
			end
			ST_SUM: begin
				cmd.acc_add_lo = 1'b1;
				state_d        = ST_SAT;
			end
			ST_SAT: begin
				cmd.sat_load = 1'b1;
				state_d      = ST_SCL;
			end
			ST_SCL: begin
				cmd.mul_en  = 1'b1;
				cmd.mul_sel = MUL_SCL;
				state_d     = ST_BIN;
			end
			ST_BIN: begin
				cmd.bin_load = 1'b1;
				state_d      = ST_RMW_RD;
			end
			ST_RMW_RD: begin
				cmd.ram_re = 1'b1;
				state_d    = ST_RMW_WR;
			end
			ST_RMW_WR: begin
				cmd.ram_we_inc = 1'b1;
				state_d        = ST_IDLE;
			end
			ST_RD_REQ: begin
				cmd.ram_re = 1'b1;
				state_d    = ST_RD_OUT;
			end
			ST_RD_OUT: begin
				if (!sts.out_busy) begin
					cmd.load_out = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule

FILE: rtl/core/qchist_dp.sv
// ----------------------------------------------------------------------------
// qchist_dp
// config registers, shared multiplier, accumulator, binning, count ram, output
// ----------------------------------------------------------------------------
module qchist_dp (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_wr_en,
	input  logic [qchist_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [qchist_pkg::CFG_DATA_W-1:0]   cfg_wr_data,
	input  logic [qchist_pkg::IN_TDATA_W-1:0]   in_tdata,
	input  qchist_pkg::qchist_cmd_t             cmd,
	output qchist_pkg::qchist_sts_t             sts,
	output logic [qchist_pkg::OUT_TDATA_W-1:0]  out_tdata,
	output logic                                out_valid,
	input  logic                                out_ready
);
	import qchist_pkg::*;

	localparam logic [DATA_W-1:0] COEF_LINEAR_RST = 32'd65536;
	localparam logic [BPU_W-1:0]  BPU_RST         = 31'd524288;
	localparam logic [NB_W-1:0]   NBINS_RST       = 9'd200;
	localparam logic [SLOT_W-1:0] SLOT_LIMIT      = SLOT_W'(SLOTS);
	localparam int                FIT_LO          = Q_FRAC + DATA_W - 1;
	localparam int                OUT_PAD_W       = OUT_TDATA_W - COUNT_W - SLOT_W;

	// configuration
	logic signed [DATA_W-1:0] coef_lin_q;
	logic signed [DATA_W-1:0] coef_quad_q;
	logic signed [DATA_W-1:0] range_low_q;
	logic [BPU_W-1:0]         bpu_q;
	logic [NB_W-1:0]          nbins_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			coef_lin_q  <= COEF_LINEAR_RST;
			coef_quad_q <= '0;
			range_low_q <= '0;
			bpu_q       <= BPU_RST;
			nbins_q     <= NBINS_RST;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				CFG_COEF_LINEAR:    coef_lin_q  <= cfg_wr_data;
				CFG_COEF_QUADRATIC: coef_quad_q <= cfg_wr_data;
				CFG_RANGE_LOW:      range_low_q <= cfg_wr_data;
				CFG_BINS_PER_UNIT:  bpu_q       <= cfg_wr_data[BPU_W-1:0];
				CFG_BINS_IN_USE:    nbins_q     <= cfg_wr_data[NB_W-1:0];
				default: ;
			endcase
		end
	end

	// item and working registers
	logic [DATA_W-1:0]        energy_q;
	logic [SLOT_W-1:0]        slot_q;
	logic signed [PROD_W-1:0] prod_q;
	logic [SQ_W-1:0]          sq_q;
	logic signed [ACC_W-1:0]  acc_q;
	logic                     under_q;
	logic [DATA_W-1:0]        diff_q;

	logic signed [MUL_W-1:0]  mul_a;
	logic signed [MUL_W-1:0]  mul_b;
	logic signed [PROD_W-1:0] mul_p;
	logic [ACC_W-1:0]         prod_ext;
	logic                     acc_fits;
	logic [DATA_W-1:0]        mapped;
	logic [DATA_W:0]          diff_full;
	logic [IDX_W-1:0]         idx;
	logic [NB_W-1:0]          nb_eff;
	logic [SLOT_W-1:0]        bin_next;

	always_comb begin
		case (cmd.mul_sel)
			MUL_SQ: begin
				mul_a = $signed({energy_q[DATA_W-1], energy_q});
				mul_b = $signed({energy_q[DATA_W-1], energy_q});
			end
			MUL_AE: begin
				mul_a = $signed({coef_lin_q[DATA_W-1], coef_lin_q});
				mul_b = $signed({energy_q[DATA_W-1], energy_q});
			end
			MUL_BH: begin
				mul_a = $signed({coef_quad_q[DATA_W-1], coef_quad_q});
				mul_b = $signed({{(MUL_W-SQ_W+Q_FRAC){1'b0}}, sq_q[SQ_W-1:Q_FRAC]});
			end
			MUL_BL: begin
				mul_a = $signed({coef_quad_q[DATA_W-1], coef_quad_q});
				mul_b = $signed({{(MUL_W-Q_FRAC){1'b0}}, sq_q[Q_FRAC-1:0]});
			end
			MUL_SCL: begin
				mul_a = $signed({1'b0, diff_q});
				mul_b = $signed({{(MUL_W-BPU_W){1'b0}}, bpu_q});
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	assign mul_p    = mul_a * mul_b;
	assign prod_ext = {{(ACC_W-PROD_W){prod_q[PROD_W-1]}}, prod_q};

	// saturate floor(acc / 2^16) to signed 32 bits, then offset by the low edge
	assign acc_fits  = (&acc_q[ACC_W-1:FIT_LO]) | ~(|acc_q[ACC_W-1:FIT_LO]);
	assign mapped    = acc_fits ? acc_q[FIT_LO:Q_FRAC] :
		(acc_q[ACC_W-1] ? {1'b1, {(DATA_W-1){1'b0}}} : {1'b0, {(DATA_W-1){1'b1}}});
	assign diff_full = {mapped[DATA_W-1], mapped} - {range_low_q[DATA_W-1], range_low_q};

	// bin selection from the scaled index
	assign idx = prod_q[IDX_W+SCALE_SHIFT-1:SCALE_SHIFT];

	always_comb begin
		if (nbins_q == '0) begin
			nb_eff = NB_W'(1);
		end else if (nbins_q > NB_W'(MAX_BINS)) begin
			nb_eff = NB_W'(MAX_BINS);
		end else begin
			nb_eff = nbins_q;
		end
		if (under_q) begin
			bin_next = '0;
		end else if (idx >= IDX_W'(nb_eff)) begin
			bin_next = SLOT_W'(nb_eff) + SLOT_W'(1);
		end else begin
			bin_next = SLOT_W'(idx) + SLOT_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_item) begin
			energy_q <= in_tdata[DATA_W-1:0];
			slot_q   <= in_tdata[DATA_W+SLOT_W-1:DATA_W];
		end else if (cmd.bin_load) begin
			slot_q <= bin_next;
		end
		if (cmd.mul_en) begin
			prod_q <= mul_p;
		end
		if (cmd.sq_load) begin
			sq_q <= prod_q[SQ_W+Q_FRAC-1:Q_FRAC];
		end
		if (cmd.acc_load) begin
			acc_q <= prod_ext;
		end else if (cmd.acc_add_hi) begin
			acc_q <= acc_q + {prod_ext[ACC_W-Q_FRAC-1:0], {Q_FRAC{1'b0}}};
		end else if (cmd.acc_add_lo) begin
			acc_q <= acc_q + prod_ext;
		end
		if (cmd.sat_load) begin
			under_q <= diff_full[DATA_W];
			diff_q  <= diff_full[DATA_W-1:0];
		end
	end

	// count memory with clearing pass
	logic [ADDR_W-1:0]  clr_addr_q;
	logic               ram_we;
	logic [ADDR_W-1:0]  ram_waddr;
	logic [COUNT_W-1:0] ram_wdata;
	logic               ram_re;
	logic [COUNT_W-1:0] ram_rdata;
	logic               slot_ok;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_addr_q <= '0;
		end else if (cmd.clr_step) begin
			clr_addr_q <= clr_addr_q + ADDR_W'(1);
		end
	end

	assign slot_ok   = slot_q < SLOT_LIMIT;
	assign ram_re    = cmd.ram_re & slot_ok;
	assign ram_we    = cmd.clr_step | cmd.ram_we_inc;
	assign ram_waddr = cmd.clr_step ? clr_addr_q : ADDR_W'(slot_q);
	assign ram_wdata = cmd.clr_step ? '0 :
		((&ram_rdata) ? ram_rdata : ram_rdata + COUNT_W'(1));

	qchist_ram #(
		.WIDTH (COUNT_W),
		.DEPTH (SLOTS)
	) u_counts (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ADDR_W'(slot_q)),
		.rdata (ram_rdata)
	);

	// result register
	logic               out_valid_q;
	logic [COUNT_W-1:0] out_count_q;
	logic [SLOT_W-1:0]  out_slot_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.load_out) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			out_count_q <= slot_ok ? ram_rdata : '0;
			out_slot_q  <= slot_q;
		end
	end

	assign out_valid = out_valid_q;
	assign out_tdata = {{OUT_PAD_W{1'b0}}, out_slot_q, out_count_q};

	assign sts.clr_done = clr_addr_q == ADDR_W'(SLOTS - 1);
	assign sts.out_busy = out_valid_q & ~out_ready;

endmodule

FILE: rtl/core/quadratic_calibrated_histogram_core.sv
// ----------------------------------------------------------------------------
// quadratic_calibrated_histogram_core
// energy histogram with calibration m = a*e + b*e*e and fixed-width bins.
// input stream: tuser = kind (fill or read), tdata = energy, read slot.
// a fill maps its sample on one shared 33x33 multiplier (square, a*e, two
// halves of b*sq, then the bin scale) and does a read-modify-write of the
// bin count, with no result transfer.
// a read returns one transfer (count, slot) from the registered ram read; the
// next item is taken after a read once the result register is free.
// the result register holds a pending result, so fills go on while the
// receiver stalls; a second read waits until the first result is taken.
// after reset a clearing pass zeroes all 258 bin counts with no item taken;
// config writes are taken at any time and used at once; write only when idle,
// which the block does not enforce. throughput is set by the controller
// sequence on the single multiplier and the count ram read-modify-write.
// ----------------------------------------------------------------------------
`include "quadratic_calibrated_histogram_core_defines.svh"

module quadratic_calibrated_histogram_core (
	input  logic                                clk,
	input  logic                                arst_n,
	// config write port
	input  logic                                cfg_wr_en,
	input  logic [qchist_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [qchist_pkg::CFG_DATA_W-1:0]   cfg_wr_data,
	// item stream in
	input  logic                                s_axis_tvalid,
	output logic                                s_axis_tready,
	input  logic [qchist_pkg::IN_TDATA_W-1:0]   s_axis_tdata,   // energy, read_slot, zero pad
	input  logic [0:0]                          s_axis_tuser,   // cmd
	// result stream out
	output logic                                m_axis_tvalid,
	input  logic                                m_axis_tready,
	output logic [qchist_pkg::OUT_TDATA_W-1:0]  m_axis_tdata    // slot_count, slot_echo, zero pad
);
	import qchist_pkg::*;

	qchist_cmd_t cmd;
	qchist_sts_t sts;

	// sequencer: one item at a time
	qchist_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_cmd   (s_axis_tuser[0]),
		.in_ready (s_axis_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	// arithmetic, counts and result register
	qchist_dp u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_index   (cfg_index),
		.cfg_wr_data (cfg_wr_data),
		.in_tdata    (s_axis_tdata),
		.cmd         (cmd),
		.sts         (sts),
		.out_tdata   (m_axis_tdata),
		.out_valid   (m_axis_tvalid),
		.out_ready   (m_axis_tready)
	);

	// no transfer in while the clearing pass runs
	`QCH_ASSERT_IMP(a_no_accept_in_clear, cmd.clr_step, !s_axis_tready)
	// a new result never overwrites one still waiting
	`QCH_ASSERT_IMP(a_no_result_overwrite, cmd.load_out, !(m_axis_tvalid && !m_axis_tready))
	// an accepted fill starts on the multiplier in the next cycle
	`QCH_ASSERT_NXT(a_fill_starts_mul,
		s_axis_tvalid && s_axis_tready && (s_axis_tuser[0] == CMD_FILL), cmd.mul_en)

endmodule
